>>> rtl/core/nsnp_pkg.sv
// ----------------------------------------------------------------------------
// nsnp_pkg: shared types and constants of the node-status name parser
// Constants of the reply layout, queue sizing and the record handed from the
// byte parser to the name trimmer.
// ----------------------------------------------------------------------------
package nsnp_pkg;

   // default byte budget of one reply
   localparam int MAX_REPLY = 2048;

   // reply layout
   localparam int NAME_LEN   = 15;   // name bytes in one entry
   localparam int HEADER_LEN = 12;   // fixed header ahead of the question name
   localparam int ENTRY_LEN  = 18;   // name, suffix, flags, one spare byte
   localparam int SUFFIX_IDX = 15;   // entry byte holding the suffix
   localparam int FLAGS_IDX  = 16;   // entry byte holding the flags

   localparam logic [7:0] LABEL_PTR_MASK = 8'hC0;  // both top bits: pointer label
   localparam logic [7:0] SUFFIX_WS      = 8'h20;  // workstation suffix
   localparam logic [7:0] SUFFIX_ZERO    = 8'h00;
   localparam logic [7:0] FIXED_SKIP     = 8'd10;  // type, class, ttl, rdlength
   localparam logic [7:0] PTR_SKIP       = 8'd11;  // pointer low byte plus the above

   // depth of the queue between parser and trimmer
   localparam int FIFO_DEPTH = 2;

   // one finished reply, as seen by the trimmer
   typedef struct packed {
      logic                         found;
      logic [NAME_LEN-1:0][7:0]     name;   // byte 0 is the first character
   } rec_type;

endpackage

>>> rtl/core/nsnp_front.sv
// ----------------------------------------------------------------------------
// nsnp_front: reply byte parser
// Walks header, question name, fixed fields, entry count and entries one byte
// per cycle; on the last byte of a reply it emits a record and restarts.
// ----------------------------------------------------------------------------
module nsnp_front #(
   parameter int MaxReply = nsnp_pkg::MAX_REPLY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output logic              rec_valid,
   output nsnp_pkg::rec_type rec_data
);

   localparam int OFF_W = $clog2(MaxReply + 1);
   localparam int IDX_W = $clog2(nsnp_pkg::ENTRY_LEN);
   localparam int BUF_W = $clog2(nsnp_pkg::NAME_LEN);

   typedef enum logic [6:0] {
      PH_HEADER     = 7'b0000001,
      PH_LABEL      = 7'b0000010,
      PH_SKIP_LABEL = 7'b0000100,
      PH_SKIP_FIXED = 7'b0001000,
      PH_COUNT      = 7'b0010000,
      PH_ENTRY      = 7'b0100000,
      PH_DONE       = 7'b1000000
   } phase_type;

   logic [OFF_W-1:0] off_ff, off_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       skip_ff, skip_in;
   logic [7:0]       count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             ok_ff, ok_in;
   logic             found_ff, found_in;
   logic [7:0]       ebuf_ff [nsnp_pkg::NAME_LEN];
   logic [nsnp_pkg::NAME_LEN-1:0][7:0] chosen_ff;
   logic             ebuf_we;
   logic             copy_en;
   logic [7:0]       skip_dec;
   logic [7:0]       count_dec;
   logic [nsnp_pkg::NAME_LEN-1:0][7:0] ebuf_flat;

   assign skip_dec  = (skip_ff  != 8'd0) ? skip_ff  - 8'd1 : 8'd0;
   assign count_dec = (count_ff != 8'd0) ? count_ff - 8'd1 : 8'd0;

   always_comb begin
      for (int i = 0; i < nsnp_pkg::NAME_LEN; i++) begin
         ebuf_flat[i] = ebuf_ff[i];
      end
   end

   // parse step for one word
   always_comb begin
      off_in   = off_ff;
      phase_in = phase_ff;
      skip_in  = skip_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      ok_in    = ok_ff;
      found_in = found_ff;
      ebuf_we  = 1'b0;
      copy_en  = 1'b0;
      if (in_valid && (off_ff < OFF_W'(MaxReply))) begin
         off_in = off_ff + OFF_W'(1);
         unique case (phase_ff)
            PH_HEADER: begin
               if (off_ff >= OFF_W'(nsnp_pkg::HEADER_LEN - 1)) begin
                  phase_in = PH_LABEL;
               end
            end
            PH_LABEL: begin
               priority if (in_byte == 8'd0) begin
                  skip_in  = nsnp_pkg::FIXED_SKIP;
                  phase_in = PH_SKIP_FIXED;
               end else if ((in_byte & nsnp_pkg::LABEL_PTR_MASK) == nsnp_pkg::LABEL_PTR_MASK) begin
                  skip_in  = nsnp_pkg::PTR_SKIP;
                  phase_in = PH_SKIP_FIXED;
               end else begin
                  skip_in  = in_byte;
                  phase_in = PH_SKIP_LABEL;
               end
            end
            PH_SKIP_LABEL: begin
               skip_in = skip_dec;
               if (skip_dec == 8'd0) begin
                  phase_in = PH_LABEL;
               end
            end
            PH_SKIP_FIXED: begin
               skip_in = skip_dec;
               if (skip_dec == 8'd0) begin
                  phase_in = PH_COUNT;
               end
            end
            PH_COUNT: begin
               count_in = in_byte;
               idx_in   = '0;
               phase_in = (in_byte != 8'd0) ? PH_ENTRY : PH_DONE;
            end
            PH_ENTRY: begin
               priority if (idx_ff < IDX_W'(nsnp_pkg::SUFFIX_IDX)) begin
                  ebuf_we = 1'b1;
                  idx_in  = idx_ff + IDX_W'(1);
               end else if (idx_ff == IDX_W'(nsnp_pkg::SUFFIX_IDX)) begin
                  ok_in  = (in_byte == nsnp_pkg::SUFFIX_ZERO) ||
                           (in_byte == nsnp_pkg::SUFFIX_WS);
                  idx_in = idx_ff + IDX_W'(1);
               end else if (idx_ff == IDX_W'(nsnp_pkg::FLAGS_IDX)) begin
                  // group names do not qualify
                  if (in_byte[7]) begin
                     ok_in = 1'b0;
                  end
                  idx_in = idx_ff + IDX_W'(1);
               end else begin
                  if (ok_ff) begin
                     copy_en  = 1'b1;
                     found_in = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     idx_in   = '0;
                     count_in = count_dec;
                     if (count_dec == 8'd0) begin
                        phase_in = PH_DONE;
                     end
                  end
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
      end

      // record reflects the state after this word
      rec_valid     = in_valid && in_last;
      rec_data.found = found_in;
      rec_data.name  = copy_en ? ebuf_flat : chosen_ff;

      // end of reply: back to reset state
      if (in_valid && in_last) begin
         off_in   = '0;
         phase_in = PH_HEADER;
         skip_in  = '0;
         count_in = '0;
         idx_in   = '0;
         ok_in    = 1'b0;
         found_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         phase_ff <= PH_HEADER;
         skip_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         ok_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         off_ff   <= off_in;
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         ok_ff    <= ok_in;
         found_ff <= found_in;
      end
   end

   // entry name buffer and chosen name
   always_ff @(posedge clock) begin
      if (ebuf_we) begin
         ebuf_ff[idx_ff[BUF_W-1:0]] <= in_byte;
      end
      if (copy_en) begin
         chosen_ff <= ebuf_flat;
      end
   end

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_last) |=> (phase_ff == PH_HEADER && off_ff == '0 && !found_ff))
      else $error("parser did not restart after end of reply");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (phase_ff == PH_DONE))
      else $error("found name while still parsing");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ENTRY) |-> (idx_ff < IDX_W'(nsnp_pkg::ENTRY_LEN)))
      else $error("entry byte index out of range");

endmodule

>>> rtl/core/nsnp_fifo.sv
// ----------------------------------------------------------------------------
// nsnp_fifo: record queue
// Short queue of finished reply records between parser and trimmer.
// ----------------------------------------------------------------------------
module nsnp_fifo #(
   parameter int Depth = nsnp_pkg::FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  nsnp_pkg::rec_type wr_data,
   output logic              full,
   input  logic              rd,
   output nsnp_pkg::rec_type rd_data,
   output logic              not_empty
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   nsnp_pkg::rec_type mem_ff [Depth];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   assign full      = (cnt_ff == CNT_W'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign do_wr     = wr && !full;
   assign do_rd     = rd && not_empty;
   assign rd_data   = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(Depth))
      else $error("record queue fill count beyond depth");

endmodule

>>> rtl/core/nsnp_trim.sv
// ----------------------------------------------------------------------------
// nsnp_trim: name trimmer
// Two stages: mark the characters that survive trimming, then align the
// trimmed name to byte 0 and hold it in the result register.
// ----------------------------------------------------------------------------
module nsnp_trim (
   input  logic              clock,
   input  logic              reset,
   input  logic              rec_valid,
   input  nsnp_pkg::rec_type rec_data,
   output logic              rec_pop,
   output logic              out_valid,
   input  logic              out_pop,
   output logic              out_found,
   output logic [3:0]        out_length,
   output logic [63:0]       out_head,
   output logic [55:0]       out_tail
);

   localparam int N = nsnp_pkg::NAME_LEN;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) ||
             (c == 8'h85) || (c == 8'hA0);
   endfunction

   logic             a_valid_ff, a_valid_in;
   logic             a_found_ff;
   logic [N-1:0][7:0] a_name_ff;
   logic [N-1:0]     a_ns_ff;
   logic             o_valid_ff, o_valid_in;
   logic             o_found_ff;
   logic [3:0]       o_len_ff;
   logic [63:0]      o_head_ff;
   logic [55:0]      o_tail_ff;

   logic [N-1:0]     keep;
   logic [N-1:0]     ns;
   logic             a_move;
   logic             take_out;
   logic [N-1:0]     below;
   logic [N-1:0]     fill;
   logic [3:0]       start;
   logic [3:0]       stop;
   logic [3:0]       len;
   logic [N*8-1:0]   shifted;
   logic [N*8-1:0]   masked;

   // stage A: survivors are non-space bytes at or before the last non-space, non-NUL byte
   always_comb begin
      for (int i = 0; i < N; i++) begin
         keep[i] = (rec_data.name[i] != 8'h20) && (rec_data.name[i] != 8'h00);
      end
      for (int i = 0; i < N; i++) begin
         ns[i] = rec_data.found && !is_space(rec_data.name[i]) && (|(keep >> i));
      end
   end

   // handshake between stages
   assign take_out   = out_pop && o_valid_ff;
   assign a_move     = a_valid_ff && (!o_valid_ff || take_out);
   assign rec_pop    = rec_valid && (!a_valid_ff || a_move);
   assign a_valid_in = rec_pop ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
   assign o_valid_in = a_move ? 1'b1 : (take_out ? 1'b0 : o_valid_ff);

   // stage B: bounds of the trimmed name, then align and clear the rest
   always_comb begin
      below = (a_ns_ff & (~a_ns_ff + N'(1))) - N'(1);
      for (int i = 0; i < N; i++) begin
         fill[i] = |(a_ns_ff >> i);
      end
      start   = 4'($countones(below));
      stop    = 4'($countones(fill));
      len     = (a_ns_ff == '0) ? 4'd0 : stop - start;
      shifted = a_name_ff >> {start, 3'b000};
      for (int p = 0; p < N; p++) begin
         masked[p*8 +: 8] = (4'(p) < len) ? shifted[p*8 +: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (rec_pop) begin
         a_found_ff <= rec_data.found;
         a_name_ff  <= rec_data.name;
         a_ns_ff    <= ns;
      end
      if (a_move) begin
         o_found_ff <= a_found_ff;
         o_len_ff   <= len;
         o_head_ff  <= masked[63:0];
         o_tail_ff  <= masked[N*8-1:64];
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_found  = o_found_ff;
   assign out_length = o_len_ff;
   assign out_head   = o_head_ff;
   assign out_tail   = o_tail_ff;

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !o_found_ff) |-> (o_len_ff == 4'd0 && o_head_ff == '0 && o_tail_ff == '0))
      else $error("result without a name carries characters");

endmodule

>>> rtl/core/netbios_status_name_parser.sv
// Path: a reply's record is held in the queue, then in trimmer stage A, then in the result register on the rsp ports.
// Throughput: one reply byte per cycle while full is low; full rises only when FifoDepth finished
// records wait in the queue behind one record in the trimmer and an untaken result.
// Reset: synchronous, active high; clears parse state, queue and result valid.
// ----------------------------------------------------------------------------
// netbios_status_name_parser: node-status reply name extractor
// Parses a node-status reply byte stream and returns the trimmed name of the
// first unique workstation entry, one result per reply.
// ----------------------------------------------------------------------------
module netbios_status_name_parser #(
   parameter int MaxReply  = nsnp_pkg::MAX_REPLY,
   parameter int FifoDepth = nsnp_pkg::FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_reply_byte,
   input  logic        req_end_of_reply,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_name_found,
   output logic [3:0]  rsp_name_length,
   output logic [63:0] rsp_name_head,
   output logic [55:0] rsp_name_tail
);

   logic              accept;
   logic              rec_wr;
   nsnp_pkg::rec_type rec_wr_data;
   logic              rec_rd;
   nsnp_pkg::rec_type rec_rd_data;
   logic              rec_avail;
   logic              out_valid;

   assign accept = push && !full;
   assign empty  = !out_valid;

   nsnp_front #(
      .MaxReply (MaxReply)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_byte   (req_reply_byte),
      .in_last   (req_end_of_reply),
      .rec_valid (rec_wr),
      .rec_data  (rec_wr_data)
   );

   nsnp_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr        (rec_wr),
      .wr_data   (rec_wr_data),
      .full      (full),
      .rd        (rec_rd),
      .rd_data   (rec_rd_data),
      .not_empty (rec_avail)
   );

   nsnp_trim u_trim (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (rec_avail),
      .rec_data   (rec_rd_data),
      .rec_pop    (rec_rd),
      .out_valid  (out_valid),
      .out_pop    (pop),
      .out_found  (rsp_name_found),
      .out_length (rsp_name_length),
      .out_head   (rsp_name_head),
      .out_tail   (rsp_name_tail)
   );

endmodule
